/* sv/interleaved_mod255_checksum_gen_assert.svh */
// Assertion macros shared by the checksum generator RTL.
`ifndef INTERLEAVED_MOD255_CHECKSUM_GEN_ASSERT_SVH
`define INTERLEAVED_MOD255_CHECKSUM_GEN_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IM255_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checksum generator assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IM255_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checksum generator assertion failed");

`endif

/* sv/im255_pkg.sv */
package im255_pkg;

    localparam int unsigned SUM_W = 10;
    localparam int unsigned LANES = 4;
    localparam logic [1:0] LANE_LAST = 2'(LANES - 1);
    localparam logic [7:0] BYTE_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] check_byte;
        logic       last_check;
    } out_item_t;

endpackage

/* sv/im255_fold.sv */
module im255_fold (
    input  logic [im255_pkg::SUM_W-1:0] sum,
    output logic [7:0]                  check
);
    import im255_pkg::*;

    logic [8:0] s1;
    logic [7:0] s2;
    logic [7:0] rem;

    // 256 == 1 mod 255: fold the high bits back in, twice
    always_comb
    begin
        s1    = {1'b0, sum[7:0]} + {7'b0, sum[9:8]};
        s2    = s1[7:0] + {7'b0, s1[8]};
        rem   = (s2 == BYTE_MAX) ? 8'h00 : s2;
        check = BYTE_MAX - rem;
    end

endmodule

/* sv/interleaved_mod255_checksum_gen.sv */
// Interleaved modulo-255 check-byte generator.
// Input channel (in_valid/in_ready/in_data): frame bytes in order, in_data.last
// marks the final byte. One byte is taken per cycle while the block is loading.
// Bytes beyond MAX_FRAME_BYTES are dropped; the frame length saturates there.
// After the final byte the block emits len/4 check bytes on the output channel
// (out_valid/out_ready/out_data), out_data.last_check on the final one. A frame
// shorter than four bytes emits nothing. Check byte i is 255 minus the mod-255
// sum of the stored bytes at i + floor(j*len/4), j = 0..3.
// The frame sits in a single-port-read RAM with a registered read port. Each
// check byte takes four reads, one wait and one push. in_ready is low from
// the final byte until the last check byte is moved to the output register.
// A stalled receiver holds the output register and the sequencer waits in
// its push step; nothing is lost.
// Reset clears the byte count, sequencer and output valid; RAM is not cleared
// and needs no clearing pass, since only entries written in the current frame
// are read.
module interleaved_mod255_checksum_gen #(
    parameter int unsigned MAX_FRAME_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  im255_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output im255_pkg::out_item_t out_data
);
    import im255_pkg::*;

    localparam int unsigned AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [7:0]       mem [MAX_FRAME_BYTES];

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    col_reg, col_next;
    logic [AW-1:0]    n_last_reg, n_last_next;
    logic [1:0]       lane_reg, lane_next;
    logic [AW-1:0]    off_reg [LANES];
    logic [AW-1:0]    off_next [LANES];
    logic             rd_vld_reg, rd_first_reg;
    logic [7:0]       rd_data_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             in_xfer;
    logic             room;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    len;
    logic [CW+1:0]    len3;
    logic             push;
    logic             last_col;
    logic [7:0]       check;

    assign in_ready  = (state_reg == S_LOAD);
    assign in_xfer   = in_valid && in_ready;
    assign room      = (count_reg < CW'(MAX_FRAME_BYTES));
    assign wr_en     = in_xfer && room;
    assign len       = count_reg + {{(CW-1){1'b0}}, room};
    assign len3      = {2'b00, len} + {1'b0, len, 1'b0};
    assign rd_en     = (state_reg == S_READ);
    assign rd_addr   = col_reg + off_reg[lane_reg];
    assign last_col  = (col_reg == n_last_reg);
    assign push      = (state_reg == S_PUSH) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    im255_fold u_fold (
        .sum   (sum_reg),
        .check (check)
    );

    // Load and emit never overlap, so the RAM needs no write-to-read forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= in_data.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        col_next       = col_reg;
        n_last_next    = n_last_reg;
        lane_next      = lane_reg;
        off_next       = off_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        sum_next       = sum_reg;

        if (rd_vld_reg)
        begin
            sum_next = (rd_first_reg ? '0 : sum_reg) + {2'b00, rd_data_reg};
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_xfer)
                begin
                    if (in_data.last)
                    begin
                        count_next = '0;
                        if (len >= CW'(LANES))
                        begin
                            n_last_next = AW'((len >> 2) - 1'b1);
                            off_next[0] = '0;
                            off_next[1] = AW'(len >> 2);
                            off_next[2] = AW'(len >> 1);
                            off_next[3] = AW'(len3 >> 2);
                            col_next    = '0;
                            lane_next   = '0;
                            state_next  = S_READ;
                        end
                    end
                    else
                    begin
                        count_next = len;
                    end
                end
            end
            S_READ:
            begin
                lane_next = lane_reg + 2'd1;
                if (lane_reg == LANE_LAST)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (push)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.check_byte = check;
                    out_data_next.last_check = last_col;
                    if (last_col)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        lane_next  = '0;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            lane_reg      <= '0;
            col_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lane_reg      <= lane_next;
            col_reg       <= col_next;
            rd_vld_reg    <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_first_reg <= (lane_reg == 2'd0);
        n_last_reg   <= n_last_next;
        off_reg      <= off_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

`include "interleaved_mod255_checksum_gen_assert.svh"

    `IM255_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(MAX_FRAME_BYTES))
    `IM255_ASSERT_IMP(a_rd_from_read, rd_vld_reg, $past(state_reg) == S_READ)
    `IM255_ASSERT_IMP(a_load_quiet, state_reg == S_LOAD, !rd_vld_reg)
    `IM255_ASSERT_NXT(a_frame_done, push && last_col,
        state_reg == S_LOAD && count_reg == '0 && out_valid_reg)

endmodule

/* dv/interleaved_mod255_checksum_gen_test.sv */
module interleaved_mod255_checksum_gen_test;
    timeunit 1ns;
    timeprecision 1ps;

    import im255_pkg::*;

    localparam int FRAME_CAP = 256;
    localparam int RANDOM_BYTES = 20;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    localparam int DIRECTED_FRAMES = 6;
    localparam int DIRECTED_LENS [DIRECTED_FRAMES] = '{1, 3, 4, 4, 5, 8};
    localparam logic [7:0] DIRECTED_BYTES [25] = '{
        8'hFF,
        8'h00, 8'h80, 8'h7F,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
        8'hFE, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFF, 8'h00
    };

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

    class checksum_board;
        logic [7:0] frame_mem [FRAME_CAP];
        int         frame_fill = 0;
        out_item_t  expected_checks [$];
        int         errors = 0;

        function logic [7:0] inv_column_sum(int pos, int len);
            int sum;
            sum = 0;
            for (int j = 0; j < LANES; j++)
            begin
                sum += frame_mem[pos + (j * len) / 4];
            end
            return 8'(255 - (sum % 255));
        endfunction

        function void note_byte(in_item_t item);
            int        len;
            out_item_t exp_item;
            if (frame_fill < FRAME_CAP)
            begin
                frame_mem[frame_fill] = item.data_byte;
                frame_fill++;
            end
            if (item.last)
            begin
                len = frame_fill;
                frame_fill = 0;
                for (int i = 0; i < len / 4; i++)
                begin
                    exp_item.check_byte = inv_column_sum(i, len);
                    exp_item.last_check = (i == len / 4 - 1);
                    expected_checks.push_back(exp_item);
                end
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_checks.size() == 0)
            begin
                errors++;
                $error("unexpected transfer: check_byte %0h last_check %0b",
                       got.check_byte, got.last_check);
                return;
            end
            want = expected_checks.pop_front();
            if (got.check_byte !== want.check_byte)
            begin
                errors++;
                $error("check_byte: expected %0h, got %0h",
                       want.check_byte, got.check_byte);
            end
            if (got.last_check !== want.last_check)
            begin
                errors++;
                $error("last_check: expected %0b, got %0b",
                       want.last_check, got.last_check);
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    in_item_t      in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    out_item_t     out_data;
    int unsigned   cycles = 0;
    checksum_board board = new();
    in_item_t      stim_q [$];

    always #4 clk = ~clk;

    interleaved_mod255_checksum_gen #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_byte(in_data);
            if (out_valid && out_ready)
                board.check_result(out_data);
        end
    end

    initial
    begin : receiver
        rx_mode_e   mode;
        logic [7:0] mask;
        forever
        begin
            mode = rx_mode_e'($urandom_range(0, 2));
            mask = 8'($urandom) | 8'h01;
            for (int k = 0; k < 64; k++)
            begin
                @(posedge clk);
                case (mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_RANDOM:  out_ready <= ($urandom_range(0, 2) != 0);
                    default:    out_ready <= mask[k % 8];
                endcase
            end
        end
    end

    function automatic void add_frame(int len);
        in_item_t item;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                item.data_byte = $urandom_range(0, 1) ? BYTE_MAX : 8'h00;
            else
                item.data_byte = 8'($urandom);
            item.last = (k == len - 1);
            stim_q.push_back(item);
        end
    endfunction

    task automatic send_frames();
        int burst_left;
        int gap;
        burst_left = 0;
        foreach (stim_q[i])
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid <= 1'b1;
            in_data <= stim_q[i];
            @(posedge clk);
            while (!in_ready) @(posedge clk);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int       pos;
        int       total;
        int       len;
        in_item_t item;

        // short frames, all-zero and all-ones columns, mixed frames
        pos = 0;
        for (int f = 0; f < DIRECTED_FRAMES; f++)
        begin
            for (int k = 0; k < DIRECTED_LENS[f]; k++)
            begin
                item.data_byte = DIRECTED_BYTES[pos];
                item.last = (k == DIRECTED_LENS[f] - 1);
                stim_q.push_back(item);
                pos++;
            end
        end

        total = 0;
        while (total < RANDOM_BYTES)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(4, 32);
            add_frame(len);
            total += len;
        end
        // overflow of a full buffer, final byte dropped
        add_frame(FRAME_CAP + $urandom_range(1, 8));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_frames();
        @(posedge clk);
        while (board.expected_checks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* interleaved_mod255_checksum_gen.f */
+incdir+sv
sv/im255_pkg.sv
sv/im255_fold.sv
sv/interleaved_mod255_checksum_gen.sv
dv/interleaved_mod255_checksum_gen_test.sv
